### rtl/core/lap5_pkg.sv
// shared types and constants of the five-point laplacian stencil
`default_nettype none
package lap5_pkg;

    localparam int SAMPLE_W    = 32;
    localparam int RESULT_W    = 35;
    localparam int OUT_TDATA_W = 40;
    localparam int RL_W        = 11;
    localparam int ROWS_W      = 16;
    localparam int ROW_CNT_W   = 17;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int OQ_DEPTH    = 3;
    localparam int OQ_PTR_W    = 2;
    localparam int OQ_CNT_W    = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOCAL_ROWS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_HALO  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_HALO  = 2'd3;

    localparam logic [RL_W-1:0]   ROW_LENGTH_RST = 11'd1024;
    localparam logic [ROWS_W-1:0] LOCAL_ROWS_RST = 16'd1;

    // per-point control decoded when the sample is accepted
    typedef struct packed {
        logic produce;
        logic use_lower;
        logic use_upper;
        logic has_left;
        logic has_right;
        logic last;
    } t_pt_ctl;

    typedef struct packed {
        logic                last;
        logic [RESULT_W-1:0] result;
    } t_oq_entry;

    typedef struct packed {
        logic [OQ_CNT_W-1:0] count;
    } t_oq_stat;

    function automatic logic signed [RESULT_W-1:0] sext(input logic [SAMPLE_W-1:0] x);
        sext = {{(RESULT_W-SAMPLE_W){x[SAMPLE_W-1]}}, x};
    endfunction

endpackage
`default_nettype wire

### rtl/core/lap5_ram.sv
// generic ram, one write port and two registered read ports
`default_nettype none
module lap5_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire logic [W-1:0]               i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0]   i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0]   i_raddr_b,
    output logic      [W-1:0]               o_rdata_a,
    output logic      [W-1:0]               o_rdata_b
);

    logic [W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule
`default_nettype wire

### rtl/core/lap5_ctrl.sv
// configuration registers, column and row counters, per-point decode
`default_nettype none
module lap5_ctrl #(
    parameter int MAX_ROW_LENGTH = 1024
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [lap5_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [lap5_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  wire logic                                  i_accept,
    output logic      [$clog2(MAX_ROW_LENGTH)-1:0]     o_col,
    output lap5_pkg::t_pt_ctl                          o_ctl
);
    import lap5_pkg::*;

    localparam int AW = $clog2(MAX_ROW_LENGTH);
    localparam int LW = (AW + 1 > RL_W) ? AW + 1 : RL_W;

    logic [RL_W-1:0]      r_row_length;
    logic [ROWS_W-1:0]    r_local_rows;
    logic                 r_has_lower;
    logic                 r_has_upper;
    logic [AW-1:0]        r_col;
    logic [ROW_CNT_W-1:0] r_row;
    logic [AW-1:0]        n_col;
    logic [ROW_CNT_W-1:0] n_row;

    logic [LW-1:0]        rl_ext;
    logic [LW-1:0]        len;
    logic [LW-1:0]        c_ext;
    logic [ROWS_W-1:0]    rows;
    logic [ROW_CNT_W-1:0] top_row;
    logic                 row_end;
    logic                 upper;

    always_comb begin
        rl_ext = LW'(r_row_length);
        if (rl_ext == '0) begin
            len = LW'(1);
        end else if (rl_ext > LW'(MAX_ROW_LENGTH)) begin
            len = LW'(MAX_ROW_LENGTH);
        end else begin
            len = rl_ext;
        end
        // a column beyond a shortened row is taken as its last column
        c_ext   = (LW'(r_col) < len) ? LW'(r_col) : len - LW'(1);
        row_end = (c_ext == len - LW'(1));
        rows    = (r_local_rows == '0) ? ROWS_W'(1) : r_local_rows;
        top_row = {1'b0, rows} + ROW_CNT_W'(1);
        upper   = (r_row >= top_row);

        o_col             = c_ext[AW-1:0];
        o_ctl.produce     = (r_row >= ROW_CNT_W'(2));
        o_ctl.use_lower   = (r_row != ROW_CNT_W'(2)) || r_has_lower;
        o_ctl.use_upper   = !upper || r_has_upper;
        o_ctl.has_left    = (c_ext != '0);
        o_ctl.has_right   = !row_end;
        o_ctl.last        = upper && row_end;

        n_col = r_col;
        n_row = r_row;
        if (i_accept) begin
            if (row_end) begin
                n_col = '0;
                n_row = upper ? '0 : r_row + ROW_CNT_W'(1);
            end else begin
                n_col = c_ext[AW-1:0] + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length <= ROW_LENGTH_RST;
            r_local_rows <= LOCAL_ROWS_RST;
            r_has_lower  <= 1'b0;
            r_has_upper  <= 1'b0;
            r_col        <= '0;
            r_row        <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_ROW_LENGTH: r_row_length <= i_cfg_data[RL_W-1:0];
                    REG_LOCAL_ROWS: r_local_rows <= i_cfg_data[ROWS_W-1:0];
                    REG_LOWER_HALO: r_has_lower  <= i_cfg_data[0];
                    REG_UPPER_HALO: r_has_upper  <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

endmodule
`default_nettype wire

### rtl/core/lap5_dp.sv
// row buffers, write forwarding and the stencil arithmetic
`default_nettype none
module lap5_dp #(
    parameter int MAX_ROW_LENGTH = 1024
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_accept,
    input  wire logic [lap5_pkg::SAMPLE_W-1:0]         i_sample,
    input  wire logic [$clog2(MAX_ROW_LENGTH)-1:0]     i_col,
    input  wire lap5_pkg::t_pt_ctl                     i_ctl,
    output logic                                       o_push,
    output lap5_pkg::t_oq_entry                        o_entry
);
    import lap5_pkg::*;

    localparam int AW = $clog2(MAX_ROW_LENGTH);

    logic                r_s1_valid;
    logic [SAMPLE_W-1:0] r_sample;
    logic [AW-1:0]       r_col;
    t_pt_ctl             r_ctl;
    logic                r_fw_mid_c;
    logic                r_fw_mid_r;
    logic                r_fw_old_c;
    logic                r_fw_old_l;
    logic [SAMPLE_W-1:0] r_fw_mid_data;
    logic [SAMPLE_W-1:0] r_fw_old_data;

    logic [AW-1:0]       addr_l;
    logic [AW-1:0]       addr_r;
    logic [SAMPLE_W-1:0] mid_c_rd;
    logic [SAMPLE_W-1:0] mid_r_rd;
    logic [SAMPLE_W-1:0] old_c_rd;
    logic [SAMPLE_W-1:0] old_l_rd;
    logic [SAMPLE_W-1:0] mid_c;
    logic [SAMPLE_W-1:0] mid_r;
    logic [SAMPLE_W-1:0] old_c;
    logic [SAMPLE_W-1:0] old_l;
    logic signed [RESULT_W-1:0] acc;

    assign addr_l = i_col - AW'(1);
    assign addr_r = i_col + AW'(1);

    // the point in the second stage writes its column at the edge where the
    // next sample reads, so a matching address takes the written value
    assign mid_c = r_fw_mid_c ? r_fw_mid_data : mid_c_rd;
    assign mid_r = r_fw_mid_r ? r_fw_mid_data : mid_r_rd;
    assign old_c = r_fw_old_c ? r_fw_old_data : old_c_rd;
    assign old_l = r_fw_old_l ? r_fw_old_data : old_l_rd;

    lap5_ram #(
        .W     (SAMPLE_W),
        .DEPTH (MAX_ROW_LENGTH)
    ) u_mid_ram (
        .i_clk     (i_clk),
        .i_we      (r_s1_valid),
        .i_waddr   (r_col),
        .i_wdata   (r_sample),
        .i_raddr_a (i_col),
        .i_raddr_b (addr_r),
        .o_rdata_a (mid_c_rd),
        .o_rdata_b (mid_r_rd)
    );

    lap5_ram #(
        .W     (SAMPLE_W),
        .DEPTH (MAX_ROW_LENGTH)
    ) u_old_ram (
        .i_clk     (i_clk),
        .i_we      (r_s1_valid),
        .i_waddr   (r_col),
        .i_wdata   (mid_c),
        .i_raddr_a (i_col),
        .i_raddr_b (addr_l),
        .o_rdata_a (old_c_rd),
        .o_rdata_b (old_l_rd)
    );

    always_comb begin
        acc = sext(mid_c) <<< 2;
        if (r_ctl.use_lower) begin
            acc = acc - sext(old_c);
        end
        if (r_ctl.use_upper) begin
            acc = acc - sext(r_sample);
        end
        if (r_ctl.has_left) begin
            acc = acc - sext(old_l);
        end
        if (r_ctl.has_right) begin
            acc = acc - sext(mid_r);
        end
    end

    assign o_push         = r_s1_valid && r_ctl.produce;
    assign o_entry.result = acc;
    assign o_entry.last   = r_ctl.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_sample      <= i_sample;
            r_col         <= i_col;
            r_ctl         <= i_ctl;
            r_fw_mid_c    <= r_s1_valid && (r_col == i_col);
            r_fw_mid_r    <= r_s1_valid && (r_col == addr_r);
            r_fw_old_c    <= r_s1_valid && (r_col == i_col);
            r_fw_old_l    <= r_s1_valid && (r_col == addr_l);
            r_fw_mid_data <= r_sample;
            r_fw_old_data <= mid_c;
        end
    end

endmodule
`default_nettype wire

### rtl/core/lap5_outq.sv
// three-entry result queue between the datapath and the output channel
`default_nettype none
module lap5_outq (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_push,
    input  wire lap5_pkg::t_oq_entry                i_entry,
    input  wire logic                               i_tready,
    output logic                                    o_tvalid,
    output lap5_pkg::t_oq_entry                     o_entry,
    output logic                                    o_space,
    output lap5_pkg::t_oq_stat                      o_stat
);
    import lap5_pkg::*;

    t_oq_entry           r_data [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] r_head;
    logic [OQ_PTR_W-1:0] r_tail;
    logic [OQ_CNT_W-1:0] r_count;
    logic                pop;

    function automatic logic [OQ_PTR_W-1:0] ptr_inc(input logic [OQ_PTR_W-1:0] p);
        ptr_inc = (p == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : p + OQ_PTR_W'(1);
    endfunction

    assign o_tvalid     = (r_count != '0);
    assign o_entry      = r_data[r_head];
    assign pop          = o_tvalid && i_tready;
    assign o_stat.count = r_count;
    // room for a new sample counts the point still in the datapath
    assign o_space      = ({1'b0, r_count} + {{OQ_CNT_W{1'b0}}, i_push})
                          <= (OQ_CNT_W + 1)'(OQ_DEPTH - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_tail <= ptr_inc(r_tail);
            end
            if (pop) begin
                r_head <= ptr_inc(r_head);
            end
            if (i_push && !pop) begin
                r_count <= r_count + OQ_CNT_W'(1);
            end else if (!i_push && pop) begin
                r_count <= r_count - OQ_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_tail] <= i_entry;
        end
    end

endmodule
`default_nettype wire

### rtl/core/laplacian_5point_stencil.sv
// five-point laplacian stencil over a streamed grid, top level
//
// Grid samples (signed Q16.16) enter on the s_axis channel row by row: the
// lower halo row, local_rows local rows, then the upper halo row, each
// row_length samples. For each sample of rows 2 .. local_rows+1 one result
// (4*u minus its four neighbours, signed Q19.16, zero-extended in tdata) leaves
// on m_axis; tlast marks the final local point of the grid.
// Each accepted sample is registered in the datapath stage, and its result is
// written into the result queue, from which m_axis is driven. One sample is
// taken every cycle while the queue has room; the two row buffers are dual-read
// memories read in the accept cycle, written in the next, forwarding in between.
// A three-entry result queue decouples the sides: s_axis_tready depends only
// on registered state and drops once the queue and the point in flight would
// fill it, so a stalled receiver stops input and loses nothing.
// Reset loads the register defaults (row_length 1024, one local row, both
// halo flags clear), zeroes the counters and empties the queue; row buffer
// contents are not cleared. Write configuration only while the block is idle.
`default_nettype none
module laplacian_5point_stencil #(
    parameter int MAX_ROW_LENGTH = 1024
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [lap5_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [lap5_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    input  wire logic [lap5_pkg::SAMPLE_W-1:0]         s_axis_tdata,  // sample
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    output logic      [lap5_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,  // result
    output logic                                       m_axis_tlast
);
    import lap5_pkg::*;

    localparam int AW = $clog2(MAX_ROW_LENGTH);

    logic      accept;
    logic [AW-1:0] col;
    t_pt_ctl   pt_ctl;
    logic      push;
    t_oq_entry dp_entry;
    t_oq_entry q_entry;
    t_oq_stat  q_stat;

    assign accept = s_axis_tvalid && s_axis_tready;

    lap5_ctrl #(
        .MAX_ROW_LENGTH (MAX_ROW_LENGTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .o_col      (col),
        .o_ctl      (pt_ctl)
    );

    lap5_dp #(
        .MAX_ROW_LENGTH (MAX_ROW_LENGTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_sample (s_axis_tdata),
        .i_col    (col),
        .i_ctl    (pt_ctl),
        .o_push   (push),
        .o_entry  (dp_entry)
    );

    lap5_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (dp_entry),
        .i_tready (m_axis_tready),
        .o_tvalid (m_axis_tvalid),
        .o_entry  (q_entry),
        .o_space  (s_axis_tready),
        .o_stat   (q_stat)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W-RESULT_W){1'b0}}, q_entry.result};
    assign m_axis_tlast = q_entry.last;

    // a result never lands in a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (q_stat.count != OQ_CNT_W'(OQ_DEPTH)))
        else $error("result pushed into a full queue");

    // a result comes only from the sample accepted in the cycle before
    a_push_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> $past(accept))
        else $error("result without a preceding sample");

    // after a push the output channel has something to offer
    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> m_axis_tvalid)
        else $error("pushed result not visible");

    // input backpressure only while results are queued
    a_stall_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (q_stat.count != '0))
        else $error("input stalled with an empty queue");

endmodule
`default_nettype wire
